// ----- src/swm_pkg.sv -----
package swm_pkg;

    // Width of one sample and of the median.
    localparam int DATA_W = 32;
    // Width of the window size register.
    localparam int WSIZE_W = 6;
    // Window size after reset.
    localparam logic [WSIZE_W-1:0] WSIZE_RESET = 6'd3;

    // What a cell hands combinationally to its right neighbor. value and valid
    // give the entry that this position holds once the oldest sample has been
    // taken out. greater is set when that entry is empty or above the new
    // sample. removed is set when the sample being dropped sits at or left of
    // this position.
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     valid;
        logic                     greater;
        logic                     removed;
    } link_t;

endpackage

// ----- src/swm_cell.sv -----
module swm_cell #(
    parameter int AW = 5
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             load,
    input  logic                             clear,
    input  logic                             start,
    input  logic                             full,
    input  logic [AW-1:0]                    rm_age,
    input  logic signed [swm_pkg::DATA_W-1:0] sample,
    input  swm_pkg::link_t                   left,
    input  logic [AW-1:0]                    left_age,
    input  logic signed [swm_pkg::DATA_W-1:0] right_value,
    input  logic [AW-1:0]                    right_age,
    input  logic                             right_valid,
    output swm_pkg::link_t                   link,
    output logic [AW-1:0]                    link_age,
    output logic signed [swm_pkg::DATA_W-1:0] value,
    output logic [AW-1:0]                    age,
    output logic                             valid
);

    logic signed [swm_pkg::DATA_W-1:0] value_reg, value_next;
    logic [AW-1:0]                     age_reg, age_next;
    logic                              valid_reg, valid_next;
    logic                              own_valid;
    logic                              match;

    // A new sequence makes every stored entry count as empty for this beat.
    assign own_valid = valid_reg && !start;
    assign match     = full && own_valid && (age_reg == rm_age);

    always_comb
    begin
        link.removed = left.removed || match;
        if (link.removed)
        begin
            link.value = right_value;
            link_age   = right_age;
            link.valid = right_valid && !start;
        end
        else
        begin
            link.value = value_reg;
            link_age   = age_reg;
            link.valid = own_valid;
        end
        link.greater = !link.valid || (link.value > sample);
    end

    always_comb
    begin
        if (left.greater)
        begin
            value_next = left.value;
            age_next   = left_age + AW'(1);
        end
        else if (link.greater)
        begin
            value_next = sample;
            age_next   = '0;
        end
        else
        begin
            value_next = link.value;
            age_next   = link_age + AW'(1);
        end
        valid_next = left.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg <= value_next;
            age_reg   <= age_next;
        end
    end

    assign value = value_reg;
    assign age   = age_reg;
    assign valid = valid_reg;

endmodule

// ----- src/sliding_window_median.sv -----
// A median waits in the cells under the pending flag, then is copied into the output register.
// Throughput: one sample per clock unless a pending median is stalled; all cells update together.
// The update path is set by the removal flag that ripples from cell to cell along the row.
// Reset clears the cell valid bits, the fill count and the output stage, and sets window_size to 3.
// No clearing pass is needed after reset; the block can take a sample as soon as reset ends.
module sliding_window_median #(
    parameter int MAX_WINDOW = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [swm_pkg::WSIZE_W-1:0]       cfg_wr_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [swm_pkg::DATA_W-1:0] sample,
    input  logic                              start_new,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [swm_pkg::DATA_W-1:0] median
);

    // Age and index width: enough to name every cell position.
    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    // Fill count width: must also hold MAX_WINDOW itself.
    localparam int CW = $clog2(MAX_WINDOW + 1);

    // The window is held as a row of cells, sorted ascending from cell 0. Each
    // cell keeps a sample and its age in beats. When the window is full, the
    // cell whose age equals window-1 is the oldest sample; it drops out while
    // the new sample is slotted into its sorted place, all in the same cycle.
    // Equal samples keep arrival order, so removal of the oldest is exact.

    logic [swm_pkg::WSIZE_W-1:0] window_size_reg;
    logic [CW-1:0]               fill_reg, fill_next;
    logic [CW-1:0]               fill_eff;
    logic [CW-1:0]               weff;
    logic [AW-1:0]               rm_age;
    logic [AW-1:0]               mid_idx;
    logic                        full;
    logic                        produce;
    logic                        accept;
    logic                        pend_reg;
    logic                        copy;
    logic                        out_valid_reg;
    logic signed [swm_pkg::DATA_W-1:0] median_reg;

    swm_pkg::link_t                    lnk     [MAX_WINDOW+1];
    logic [AW-1:0]                     lnk_age [MAX_WINDOW+1];
    logic signed [swm_pkg::DATA_W-1:0] cell_value [MAX_WINDOW];
    logic [AW-1:0]                     cell_age   [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]             cell_valid;

    // Effective window: zero acts as one, values above the row length clip.
    always_comb
    begin
        if (window_size_reg == '0)
        begin
            weff = CW'(1);
        end
        else if (int'(window_size_reg) > MAX_WINDOW)
        begin
            weff = CW'(MAX_WINDOW);
        end
        else
        begin
            weff = CW'(window_size_reg);
        end
    end

    assign rm_age  = AW'(weff - CW'(1));
    assign mid_idx = AW'((weff - CW'(1)) >> 1);

    // A start flag empties the window before its own sample enters.
    assign fill_eff  = start_new ? '0 : fill_reg;
    assign full      = (fill_eff == weff);
    assign fill_next = full ? fill_eff : fill_eff + CW'(1);
    assign produce   = full || (fill_next == weff);

    // The pending flag marks that the cells hold a median not yet moved into
    // the output register. It frees as soon as the output stage can take it,
    // so a new beat is taken in every cycle while the output flows.
    assign copy     = pend_reg && (!out_valid_reg || !out_stall);
    assign in_stall = pend_reg && !copy;
    assign accept   = in_valid && !in_stall;

    // Left end of the row: nothing removed yet, position zero always filled.
    assign lnk[0].value   = '0;
    assign lnk[0].valid   = 1'b1;
    assign lnk[0].greater = 1'b0;
    assign lnk[0].removed = 1'b0;
    assign lnk_age[0]     = '0;

    for (genvar i = 0; i < MAX_WINDOW; i++)
    begin : g_cell
        logic signed [swm_pkg::DATA_W-1:0] right_value;
        logic [AW-1:0]                     right_age;
        logic                              right_valid;

        if (i == MAX_WINDOW - 1)
        begin : g_end
            assign right_value = '0;
            assign right_age   = '0;
            assign right_valid = 1'b0;
        end
        else
        begin : g_mid
            assign right_value = cell_value[i+1];
            assign right_age   = cell_age[i+1];
            assign right_valid = cell_valid[i+1];
        end

        swm_cell #(
            .AW (AW)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .load        (accept),
            .clear       (cfg_wr_en),
            .start       (start_new),
            .full        (full),
            .rm_age      (rm_age),
            .sample      (sample),
            .left        (lnk[i]),
            .left_age    (lnk_age[i]),
            .right_value (right_value),
            .right_age   (right_age),
            .right_valid (right_valid),
            .link        (lnk[i+1]),
            .link_age    (lnk_age[i+1]),
            .value       (cell_value[i]),
            .age         (cell_age[i]),
            .valid       (cell_valid[i])
        );
    end

    // Window size and fill count. A register write starts a new sequence.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= swm_pkg::WSIZE_RESET;
            fill_reg        <= '0;
        end
        else if (cfg_wr_en)
        begin
            window_size_reg <= cfg_wr_data;
            fill_reg        <= '0;
        end
        else if (accept)
        begin
            fill_reg <= fill_next;
        end
    end

    // Pending flag and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                pend_reg <= produce;
            end
            else if (copy)
            begin
                pend_reg <= 1'b0;
            end

            if (copy)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (copy)
        begin
            median_reg <= cell_value[mid_idx];
        end
    end

    assign out_valid = out_valid_reg;
    assign median    = median_reg;

    // Filled cells always form one run starting at cell 0.
    a_valid_run: assert property (@(posedge clk) disable iff (!rst_n)
        ((cell_valid + MAX_WINDOW'(1)) & cell_valid) == '0)
        else $error("cell valid bits are not a contiguous run from cell 0");

    // The fill count tracks the number of filled cells.
    a_fill_count: assert property (@(posedge clk) disable iff (!rst_n)
        int'(fill_reg) == $countones(cell_valid))
        else $error("fill count disagrees with filled cells");

    // A beat that completes a window leaves a median pending.
    a_pend_set: assert property (@(posedge clk) disable iff (!rst_n)
        accept && produce && !cfg_wr_en |=> pend_reg)
        else $error("median lost after a full-window beat");

    // The input only stalls while a median waits on a blocked output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (pend_reg && out_valid_reg && out_stall))
        else $error("input stalled without a blocked median");

endmodule

// ----- dv/sliding_window_median_tb.sv -----
`timescale 1ns / 1ps

module sliding_window_median_tb;

    // Largest window that the block holds; larger register values are clamped to it.
    localparam int MAX_WIN = 32;
    // Cycles to let pass after the last expected median before touching the register.
    // A sample that completes no window gives no beat; the block is done with it
    // at the edge that takes it.
    localparam int SETTLE_CYCLES = 4;
    // The watchdog ends the run after this many cycles in which no beat moves.
    localparam int QUIET_LIMIT = 2000;
    // Only the first few mismatches are printed in full.
    localparam int REPORT_LIMIT = 10;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [swm_pkg::WSIZE_W-1:0] cfg_wr_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [swm_pkg::DATA_W-1:0] sample = '0;
    logic start_new = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [swm_pkg::DATA_W-1:0] median;

    sliding_window_median #(
        .MAX_WINDOW(MAX_WIN)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .sample(sample),
        .start_new(start_new),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .median(median)
    );

    always #6 clk = ~clk;

    // Mirror of the filter state. The window register is kept as written; the
    // clamping to 1..MAX_WIN happens when a sample is taken in.
    logic [swm_pkg::WSIZE_W-1:0] win_reg = swm_pkg::WSIZE_RESET;
    logic signed [swm_pkg::DATA_W-1:0] arrival_ring [MAX_WIN];
    logic signed [swm_pkg::DATA_W-1:0] ordered_win [MAX_WIN];
    int oldest_slot = 0;
    int fill_level = 0;

    // Medians that the block still owes, oldest first.
    logic signed [swm_pkg::DATA_W-1:0] expected_medians [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int error_count = 0;
    int samples_sent = 0;
    int medians_checked = 0;
    int window_writes = 0;
    int quiet_cycles = 0;

    function automatic int active_window();
        if (win_reg == 0)
            return 1;
        if (win_reg > MAX_WIN)
            return MAX_WIN;
        return int'(win_reg);
    endfunction

    // Takes the first sorted entry equal to the leaving sample out of the window.
    function automatic void drop_ordered(logic signed [swm_pkg::DATA_W-1:0] leaving);
        int pos;
        pos = -1;
        for (int i = 0; i < fill_level; i++)
        begin
            if (ordered_win[i] == leaving)
            begin
                pos = i;
                break;
            end
        end
        if (pos < 0)
            return;
        for (int i = pos; i + 1 < fill_level; i++)
            ordered_win[i] = ordered_win[i + 1];
        fill_level--;
    endfunction

    function automatic void insert_ordered(logic signed [swm_pkg::DATA_W-1:0] arriving);
        int i;
        i = fill_level;
        while (i > 0 && ordered_win[i - 1] > arriving)
        begin
            ordered_win[i] = ordered_win[i - 1];
            i--;
        end
        ordered_win[i] = arriving;
        fill_level++;
    endfunction

    // Updates the mirror with one accepted sample and returns 1 when the
    // window is full, with the lower median in med.
    function automatic bit predict_median(input logic signed [swm_pkg::DATA_W-1:0] s,
                                          input logic fresh,
                                          output logic signed [swm_pkg::DATA_W-1:0] med);
        int w;
        int slot;
        w = active_window();
        med = '0;
        if (fresh || fill_level > w)
        begin
            fill_level = 0;
            oldest_slot = 0;
        end
        if (oldest_slot >= w)
            oldest_slot = 0;
        if (fill_level == w)
        begin
            slot = oldest_slot;
            drop_ordered(arrival_ring[slot]);
            arrival_ring[slot] = s;
            oldest_slot = (oldest_slot + 1 >= w) ? 0 : oldest_slot + 1;
        end
        else
        begin
            slot = (oldest_slot + fill_level) % w;
            arrival_ring[slot] = s;
        end
        insert_ordered(s);
        if (fill_level == w)
        begin
            med = ordered_win[(w - 1) / 2];
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("[%0t] %s", $realtime, msg);
    endtask

    // The receiver stalls at random with the probability of the current phase.
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_idle_pct);

    // Every median beat that the block hands over is compared with the oldest
    // prediction. Outputs are read at the edge, before the block updates them.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_medians.size() == 0)
                report_mismatch($sformatf("median beat %0d arrived with none expected",
                                          median));
            else
            begin
                if (median !== expected_medians[0])
                    report_mismatch($sformatf("median mismatch: expected %0d, got %0d",
                                              expected_medians[0], median));
                void'(expected_medians.pop_front());
                medians_checked++;
            end
        end
    end

    // Any beat, in either direction, or a register write counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= QUIET_LIMIT)
        begin
            $display("watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Sends one sample beat, after an optional random gap, and returns at the
    // edge where the block takes it. valid stays high on return so that a
    // back-to-back beat needs no second assignment in the same step.
    task automatic send_sample(input logic signed [swm_pkg::DATA_W-1:0] s, input logic fresh);
        logic signed [swm_pkg::DATA_W-1:0] med;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample <= s;
        start_new <= fresh;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        samples_sent++;
        if (predict_median(s, fresh, med))
            expected_medians.push_back(med);
    endtask

    // Holds the sender back until every predicted median has come out and the
    // pipeline has had time to finish any sample that produced no beat.
    task automatic drain_block();
        in_valid <= 1'b0;
        while (expected_medians.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register writes happen only with the block empty. A write also restarts
    // the sequence, so the mirror drops its fill count as well.
    task automatic write_window(input logic [swm_pkg::WSIZE_W-1:0] value);
        drain_block();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        win_reg = value;
        fill_level = 0;
        oldest_slot = 0;
        window_writes++;
    endtask

    function automatic logic signed [swm_pkg::DATA_W-1:0] pick_sample(input int style);
        case (style)
            0: return $urandom();
            // A narrow range makes equal samples common, so removal of duplicates is hit.
            1: return swm_pkg::DATA_W'(int'($urandom_range(8)) - 4);
            2:
            begin
                case ($urandom_range(4))
                    0: return {1'b1, {(swm_pkg::DATA_W-1){1'b0}}};
                    1: return {1'b0, {(swm_pkg::DATA_W-1){1'b1}}};
                    2: return '0;
                    3: return '1;
                    default: return swm_pkg::DATA_W'(1);
                endcase
            end
            default: return swm_pkg::DATA_W'(int'($urandom_range(2000)) - 1000);
        endcase
    endfunction

    // With the window left at its reset value of 3, the most negative and most
    // positive samples, zero and minus one pass through, then a new sequence
    // is started by the flag and filled with equal samples.
    task automatic test_reset_window_extremes();
        send_sample({1'b1, {(swm_pkg::DATA_W-1){1'b0}}}, 1'b0);
        send_sample({1'b0, {(swm_pkg::DATA_W-1){1'b1}}}, 1'b0);
        send_sample('0, 1'b0);
        send_sample('1, 1'b0);
        send_sample({1'b0, {(swm_pkg::DATA_W-1){1'b1}}}, 1'b0);
        send_sample(swm_pkg::DATA_W'(5), 1'b1);
        send_sample(swm_pkg::DATA_W'(5), 1'b0);
        send_sample(swm_pkg::DATA_W'(5), 1'b0);
        drain_block();
    endtask

    // A zero window behaves as a window of one, an even window gives the lower
    // of the two middle values, and rewriting the register part way through a
    // sequence throws the partial window away.
    task automatic test_window_register_cases();
        write_window('0);
        send_sample(swm_pkg::DATA_W'(-7), 1'b0);
        send_sample(32'sh5555_5555, 1'b0);
        send_sample(32'shAAAA_AAAA, 1'b0);
        write_window(6'd2);
        send_sample(swm_pkg::DATA_W'(10), 1'b0);
        send_sample(swm_pkg::DATA_W'(10), 1'b0);
        send_sample(swm_pkg::DATA_W'(3), 1'b0);
        send_sample(swm_pkg::DATA_W'(10), 1'b0);
        write_window(6'd4);
        send_sample(swm_pkg::DATA_W'(1), 1'b0);
        send_sample(swm_pkg::DATA_W'(2), 1'b0);
        write_window(6'd4);
        send_sample(swm_pkg::DATA_W'(9), 1'b0);
        send_sample(swm_pkg::DATA_W'(8), 1'b0);
        send_sample(swm_pkg::DATA_W'(7), 1'b0);
        send_sample(swm_pkg::DATA_W'(6), 1'b0);
        drain_block();
    endtask

    // Random sequences: most begin with a register write and run past the fill
    // point, some restart through the start flag alone, a few stop short of a
    // full window, and the flag is raised at random now and then as noise.
    task automatic test_random_sequences(input int budget, input int s_pct, input int r_pct);
        int phase_start;
        int w;
        int run_len;
        int style;
        int pick;
        bit by_flag;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        phase_start = samples_sent;
        while (samples_sent - phase_start < budget)
        begin
            by_flag = ($urandom_range(99) < 25);
            if (by_flag)
            begin
                // Now and then the sender waits for every owed median first.
                if ($urandom_range(2) == 0)
                    drain_block();
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 60)
                    write_window(swm_pkg::WSIZE_W'($urandom_range(1, 8)));
                else if (pick < 80)
                    write_window(swm_pkg::WSIZE_W'($urandom_range(9, 31)));
                else if (pick < 88)
                    write_window(swm_pkg::WSIZE_W'(MAX_WIN));
                else if (pick < 94)
                    write_window(swm_pkg::WSIZE_W'($urandom_range(MAX_WIN + 1, 63)));
                else
                    write_window('0);
            end
            w = active_window();
            if ($urandom_range(99) < 10)
                run_len = $urandom_range(1, w);
            else
                run_len = w + $urandom_range(0, 24);
            style = $urandom_range(3);
            for (int k = 0; k < run_len; k++)
                send_sample(pick_sample(style),
                            (k == 0 && by_flag) || ($urandom_range(99) < 2));
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_window_extremes();
        test_window_register_cases();
        test_random_sequences(550, 13, 46);
        test_random_sequences(550, 46, 13);
        test_random_sequences(550, 0, 0);
        drain_block();

        if (expected_medians.size() != 0)
            report_mismatch($sformatf("%0d medians never arrived", expected_medians.size()));

        $display("run covered %0d sample beats, %0d medians checked, %0d window writes",
                 samples_sent, medians_checked, window_writes);
        $display("windows from zero to the clamped maximum, start flags and stall phases");
        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
